[rtl/ttaw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ttaw_pkg;

   // Screen geometry
   localparam int COLUMNS      = 80;
   localparam int ROWS         = 25;
   localparam int TAB_WIDTH    = 8;
   localparam int SCREEN_CELLS = ROWS * COLUMNS;

   // Attribute values
   localparam logic [7:0] ATTR_RESET   = 8'h0f;
   localparam logic [7:0] ATTR_DEFAULT = 8'h07;
   localparam int         ATTR_BOLD_BIT      = 3;
   localparam int         ATTR_UNDERLINE_BIT = 0;
   localparam int         ATTR_BLINK_BIT     = 7;

   // Plain control bytes
   localparam logic [7:0] CHAR_BS        = 8'h08;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_LF        = 8'h0A;
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_ESC       = 8'h1B;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_NINE      = 8'h39;
   localparam logic [7:0] CHAR_SEMICOLON = 8'h3B;
   localparam logic [7:0] CHAR_LBRACKET  = 8'h5B;

   // Final bytes of an ESC [ sequence
   localparam logic [7:0] CSI_CURSOR_UP      = 8'h41;
   localparam logic [7:0] CSI_CURSOR_DOWN    = 8'h42;
   localparam logic [7:0] CSI_CURSOR_FORWARD = 8'h43;
   localparam logic [7:0] CSI_CURSOR_BACK    = 8'h44;
   localparam logic [7:0] CSI_NEXT_LINE      = 8'h45;
   localparam logic [7:0] CSI_PREV_LINE      = 8'h46;
   localparam logic [7:0] CSI_COLUMN_ABS     = 8'h47;
   localparam logic [7:0] CSI_POSITION       = 8'h48;
   localparam logic [7:0] CSI_POSITION_ALT   = 8'h66;
   localparam logic [7:0] CSI_SGR            = 8'h6D;

   // Graphic rendition codes
   localparam logic [7:0] SGR_RESET          = 8'd0;
   localparam logic [7:0] SGR_BOLD           = 8'd1;
   localparam logic [7:0] SGR_UNDERLINE      = 8'd4;
   localparam logic [7:0] SGR_BLINK          = 8'd5;
   localparam logic [7:0] SGR_REVERSE        = 8'd7;
   localparam logic [7:0] SGR_NORMAL         = 8'd22;
   localparam logic [7:0] SGR_FG_BASE        = 8'd30;
   localparam logic [7:0] SGR_BG_BASE        = 8'd40;
   localparam logic [7:0] SGR_FG_BRIGHT_BASE = 8'd90;
   localparam logic [7:0] SGR_BG_BRIGHT_BASE = 8'd100;
   localparam logic [7:0] SGR_COLOUR_SPAN    = 8'd7;

   // Register indexes
   localparam logic CSR_UNDERLINE_ENABLE = 1'b0;
   localparam logic CSR_BLINK_ENABLE     = 1'b1;

   // ANSI colour order to text-mode colour order
   localparam logic [2:0] ANSI_TO_VGA [8] = '{3'd0, 3'd4, 3'd2, 3'd6,
                                              3'd1, 3'd5, 3'd3, 3'd7};

   typedef logic [7:0] tab_table_type [256];

   function automatic tab_table_type build_tab_table();
      tab_table_type t;
      for (int i = 0; i < 256; i++) begin
         t[i] = 8'(((i / TAB_WIDTH) + 1) * TAB_WIDTH);
      end
      return t;
   endfunction

   // Next tab stop for every column, wrapped to 8 bits
   localparam tab_table_type TAB_STOP = build_tab_table();

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_ESC  = 2'd1,
      MODE_CSI  = 2'd2
   } parse_mode_type;

   typedef struct packed {
      logic underline_enable;
      logic blink_enable;
   } cfg_type;

   typedef struct packed {
      logic        cell_write;
      logic [10:0] cell_address;
      logic [15:0] cell_value;
      logic [15:0] cursor_position;
   } result_type;

endpackage

`default_nettype wire

[rtl/ttaw_sgr.sv]
`timescale 1ns / 1ps
`default_nettype none

module ttaw_sgr (
   input  wire logic [7:0]       param,
   input  wire logic [7:0]       attr,
   input  wire ttaw_pkg::cfg_type cfg,
   output logic [7:0]            attr_next
);
   import ttaw_pkg::*;

   logic [7:0] fg_off;
   logic [7:0] fgb_off;
   logic [7:0] bg_off;
   logic [7:0] bgb_off;

   assign fg_off  = param - SGR_FG_BASE;
   assign fgb_off = param - SGR_FG_BRIGHT_BASE;
   assign bg_off  = param - SGR_BG_BASE;
   assign bgb_off = param - SGR_BG_BRIGHT_BASE;

   always_comb begin
      attr_next = attr;
      priority if (param == SGR_RESET) begin
         attr_next = ATTR_DEFAULT;
      end else if (param == SGR_BOLD) begin
         attr_next[ATTR_BOLD_BIT] = 1'b1;
      end else if (param == SGR_UNDERLINE && cfg.underline_enable) begin
         attr_next[ATTR_UNDERLINE_BIT] = 1'b1;
      end else if (param == SGR_BLINK && cfg.blink_enable) begin
         attr_next[ATTR_BLINK_BIT] = 1'b1;
      end else if (param == SGR_REVERSE) begin
         attr_next = {attr[3:0], attr[7:4]};
      end else if (param == SGR_NORMAL) begin
         attr_next[ATTR_BOLD_BIT] = 1'b0;
      end else if (param >= SGR_FG_BASE && param <= SGR_FG_BASE + SGR_COLOUR_SPAN) begin
         attr_next[3:0] = {1'b0, ANSI_TO_VGA[fg_off[2:0]]};
      end else if (param >= SGR_FG_BRIGHT_BASE
                   && param <= SGR_FG_BRIGHT_BASE + SGR_COLOUR_SPAN) begin
         attr_next[3:0] = {1'b1, ANSI_TO_VGA[fgb_off[2:0]]};
      end else if (param >= SGR_BG_BASE && param <= SGR_BG_BASE + SGR_COLOUR_SPAN) begin
         attr_next[7:4] = {1'b0, ANSI_TO_VGA[bg_off[2:0]]};
      end else if (param >= SGR_BG_BRIGHT_BASE
                   && param <= SGR_BG_BRIGHT_BASE + SGR_COLOUR_SPAN) begin
         attr_next[7:4] = {1'b1, ANSI_TO_VGA[bgb_off[2:0]]};
      end else begin
         attr_next = attr;
      end
   end

endmodule

`default_nettype wire

[rtl/ttaw_engine.sv]
`timescale 1ns / 1ps
`default_nettype none

module ttaw_engine (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step_en,
   input  wire logic [7:0]           char_byte,
   input  wire ttaw_pkg::cfg_type    cfg,
   output ttaw_pkg::result_type      result
);
   import ttaw_pkg::*;

   logic [7:0]     col_ff, col_in;
   logic [7:0]     row_ff, row_in;
   logic [7:0]     attr_ff, attr_in;
   parse_mode_type mode_ff, mode_in;
   logic [7:0]     cur_ff, cur_in;
   logic [7:0]     first_ff, first_in;
   logic           two_ff, two_in;

   logic [15:0] lin;
   logic [15:0] emit_addr;
   logic [7:0]  emit_char;
   logic        emit;
   logic        plain;
   logic        last_row;
   logic [7:0]  tab_col;
   logic [7:0]  sgr_attr;
   logic [7:0]  digit_off;
   logic [15:0] cursor_lin;

   assign lin       = 16'(row_ff) * 16'(COLUMNS) + 16'(col_ff);
   assign last_row  = ({1'b0, row_ff} + 9'd1) == 9'(ROWS);
   assign tab_col   = TAB_STOP[col_ff];
   assign digit_off = char_byte - CHAR_ZERO;

   ttaw_sgr u_sgr (
      .param     (cur_ff),
      .attr      (attr_ff),
      .cfg       (cfg),
      .attr_next (sgr_attr)
   );

   always_comb begin
      col_in    = col_ff;
      row_in    = row_ff;
      attr_in   = attr_ff;
      mode_in   = mode_ff;
      cur_in    = cur_ff;
      first_in  = first_ff;
      two_in    = two_ff;
      emit      = 1'b0;
      emit_addr = lin;
      emit_char = char_byte;
      plain     = 1'b0;

      unique case (mode_ff)
         MODE_ESC: begin
            if (char_byte == CHAR_LBRACKET) begin
               mode_in  = MODE_CSI;
               cur_in   = 8'd0;
               first_in = 8'd0;
               two_in   = 1'b0;
            end else begin
               mode_in = MODE_IDLE;
               plain   = 1'b1;
            end
         end
         MODE_CSI: begin
            priority if (char_byte >= CHAR_ZERO && char_byte <= CHAR_NINE) begin
               cur_in = cur_ff * 8'd10 + {4'd0, digit_off[3:0]};
            end else if (char_byte == CHAR_SEMICOLON) begin
               first_in = cur_ff;
               cur_in   = 8'd0;
               two_in   = 1'b1;
            end else begin
               mode_in = MODE_IDLE;
               case (char_byte)
                  CSI_CURSOR_UP:      row_in = (cur_ff > row_ff) ? 8'd0 : row_ff - cur_ff;
                  CSI_CURSOR_DOWN:    row_in = row_ff + cur_ff;
                  CSI_CURSOR_FORWARD: col_in = col_ff + cur_ff;
                  CSI_CURSOR_BACK:    col_in = col_ff - cur_ff;
                  CSI_NEXT_LINE: begin
                     col_in = 8'd0;
                     row_in = row_ff + cur_ff;
                  end
                  CSI_PREV_LINE: begin
                     col_in = 8'd0;
                     row_in = row_ff - cur_ff;
                  end
                  CSI_COLUMN_ABS:     col_in = cur_ff;
                  CSI_POSITION, CSI_POSITION_ALT: begin
                     if (two_ff) begin
                        col_in = first_ff;
                        row_in = cur_ff;
                     end
                  end
                  CSI_SGR:            attr_in = sgr_attr;
                  default:            ;
               endcase
            end
         end
         default: begin
            // idle, and the spare code too
            mode_in = MODE_IDLE;
            plain   = 1'b1;
         end
      endcase

      if (plain) begin
         case (char_byte)
            CHAR_CR: col_in = 8'd0;
            CHAR_LF: begin
               col_in = 8'd0;
               row_in = last_row ? row_ff : row_ff + 8'd1;
            end
            CHAR_BS: begin
               if (col_ff != 8'd0) begin
                  col_in    = col_ff - 8'd1;
                  emit      = 1'b1;
                  emit_addr = lin - 16'd1;
                  emit_char = CHAR_SPACE;
               end
            end
            CHAR_TAB: begin
               if (16'(tab_col) < 16'(COLUMNS)) begin
                  col_in = tab_col;
               end else begin
                  col_in = 8'd0;
                  row_in = last_row ? row_ff : row_ff + 8'd1;
               end
            end
            CHAR_ESC: mode_in = MODE_ESC;
            default: begin
               emit   = 1'b1;
               col_in = col_ff + 8'd1;
            end
         endcase
      end
   end

   assign cursor_lin = 16'(row_in) * 16'(COLUMNS) + 16'(col_in);

   always_comb begin
      result = '0;
      result.cursor_position = cursor_lin;
      if (emit && emit_addr < 16'(SCREEN_CELLS)) begin
         result.cell_write   = 1'b1;
         result.cell_address = emit_addr[10:0];
         result.cell_value   = {attr_ff, emit_char};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= 8'd0;
         row_ff   <= 8'd0;
         attr_ff  <= ATTR_RESET;
         mode_ff  <= MODE_IDLE;
         cur_ff   <= 8'd0;
         first_ff <= 8'd0;
         two_ff   <= 1'b0;
      end else if (step_en) begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         attr_ff  <= attr_in;
         mode_ff  <= mode_in;
         cur_ff   <= cur_in;
         first_ff <= first_in;
         two_ff   <= two_in;
      end
   end

endmodule

`default_nettype wire

[rtl/text_terminal_ansi_writer_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Path: a word accepted on req_ waits in the input register, then passes through the
//   state update into the result register, which shows it on rsp_.
// Throughput: one word per cycle while rsp_stall is low, set by the loop through the
//   cursor, attribute and parser registers.
// Reset (synchronous, high): empties both stages, cursor to 0,0, attribute 0x0f,
//   parser idle, both enables cleared.
module text_terminal_ansi_writer_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_input_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_cell_write,
   output logic [10:0]      rsp_cell_address,
   output logic [15:0]      rsp_cell_value,
   output logic [15:0]      rsp_cursor_position,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_index,
   input  wire logic        csr_write_data
);
   import ttaw_pkg::*;

   // Configuration registers
   cfg_type cfg_ff;

   // Input stage: holds the byte waiting for the state update
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // Result stage
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   result_type step_result;

   logic req_accept;
   logic step_en;

   // Advance the input word whenever the result register is free or being drained.
   assign step_en    = in_valid_ff && (!out_valid_ff || !rsp_stall);
   // Stall the source only while the input word cannot move on.
   assign req_stall  = in_valid_ff && !step_en;
   assign req_accept = req_valid && !req_stall;

   assign in_valid_in  = req_accept || (in_valid_ff && !step_en);
   assign out_valid_in = step_en || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_UNDERLINE_ENABLE: cfg_ff.underline_enable <= csr_write_data;
            CSR_BLINK_ENABLE:     cfg_ff.blink_enable     <= csr_write_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers carry no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_input_byte;
      end
      if (step_en) begin
         out_ff <= step_result;
      end
   end

   // Cursor, attribute and escape parser; updates once per advanced word
   ttaw_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .char_byte (in_byte_ff),
      .cfg       (cfg_ff),
      .result    (step_result)
   );

   assign rsp_valid           = out_valid_ff;
   assign rsp_cell_write      = out_ff.cell_write;
   assign rsp_cell_address    = out_ff.cell_address;
   assign rsp_cell_value      = out_ff.cell_value;
   assign rsp_cursor_position = out_ff.cursor_position;

   // A stalled source means both stages are full and the sink is holding.
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("input stalled with room in the pipe");

   // A held result is not overwritten.
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(out_ff)))
      else $error("held result changed");

   // Off-screen writes are dropped.
   a_write_on_screen: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_cell_write) |-> (rsp_cell_address < 11'(SCREEN_CELLS)))
      else $error("cell write beyond the screen");

   // No write means a cleared address and value.
   a_no_write_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_cell_write) |-> (rsp_cell_address == 11'd0
                                          && rsp_cell_value == 16'd0))
      else $error("idle cell fields not cleared");

   // Both stages are empty straight after reset.
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !in_valid_ff))
      else $error("pipe not empty after reset");

endmodule

`default_nettype wire

[sim/tb_text_terminal_ansi_writer_core.sv]
`timescale 1ns / 1ps

module tb_text_terminal_ansi_writer_core;
   import ttaw_pkg::*;

   localparam int ITEMS_PER_PHASE = 67;
   localparam int PHASES          = 6;
   localparam int SETTLE_CYCLES   = 4;
   localparam int STALL_LIMIT     = 5000;

   // Erase commands are not implemented; they must close a sequence quietly
   localparam logic [7:0] CSI_ERASE_DISPLAY = 8'h4A;
   localparam logic [7:0] CSI_ERASE_LINE    = 8'h4B;

   // Screen state tracker and store of expected result words
   class cell_scoreboard;
      logic [7:0]     col, row, attr, param, first_param;
      logic           two_params, underline_on, blink_on;
      parse_mode_type mode;
      result_type     expected_q[$];
      int             mismatches, bytes_noted, cells_written, cells_dropped, sequences_done;

      function new();
         col            = '0;
         row            = '0;
         attr           = ATTR_RESET;
         param          = '0;
         first_param    = '0;
         two_params     = 1'b0;
         underline_on   = 1'b0;
         blink_on       = 1'b0;
         mode           = MODE_IDLE;
         mismatches     = 0;
         bytes_noted    = 0;
         cells_written  = 0;
         cells_dropped  = 0;
         sequences_done = 0;
      endfunction

      function void set_enables(logic underline, logic blink);
         underline_on = underline;
         blink_on     = blink;
      endfunction

      function int unsigned cursor_index();
         return int'(row) * COLUMNS + int'(col);
      endfunction

      function void write_cell(inout result_type r, input logic [7:0] ch);
         int unsigned addr;
         addr = cursor_index();
         if (addr < SCREEN_CELLS) begin
            r.cell_write   = 1'b1;
            r.cell_address = 11'(addr);
            r.cell_value   = {attr, ch};
            cells_written++;
         end else begin
            cells_dropped++;
         end
      endfunction

      // No scroll: the last row stays put
      function void next_line();
         if (int'(row) + 1 != ROWS) row++;
         col = '0;
      endfunction

      function void plain_byte(logic [7:0] c, inout result_type r);
         int unsigned stop;
         case (c)
            CHAR_CR: col = '0;
            CHAR_LF: next_line();
            CHAR_BS: if (col != 0) begin
               col--;
               write_cell(r, CHAR_SPACE);
            end
            CHAR_TAB: begin
               stop = ((int'(col) / TAB_WIDTH) + 1) * TAB_WIDTH % 256;
               if (stop < COLUMNS) col = 8'(stop);
               else next_line();
            end
            CHAR_ESC: mode = MODE_ESC;
            default: begin
               write_cell(r, c);
               col++;
            end
         endcase
      endfunction

      // ANSI order is R,G,B from bit 0; text mode is B,G,R from bit 0
      function logic [3:0] text_colour(logic [7:0] code, logic [7:0] base, logic bright);
         logic [2:0] ansi;
         ansi = 3'(code - base);
         return {bright, ansi[0], ansi[1], ansi[2]};
      endfunction

      function bit in_span(logic [7:0] n, logic [7:0] base);
         return n >= base && n <= base + SGR_COLOUR_SPAN;
      endfunction

      function void graphic_rendition(logic [7:0] n);
         if (n == SGR_RESET) attr = ATTR_DEFAULT;
         else if (n == SGR_BOLD) attr[ATTR_BOLD_BIT] = 1'b1;
         else if (n == SGR_UNDERLINE && underline_on) attr[ATTR_UNDERLINE_BIT] = 1'b1;
         else if (n == SGR_BLINK && blink_on) attr[ATTR_BLINK_BIT] = 1'b1;
         else if (n == SGR_REVERSE) attr = {attr[3:0], attr[7:4]};
         else if (n == SGR_NORMAL) attr[ATTR_BOLD_BIT] = 1'b0;
         else if (in_span(n, SGR_FG_BASE)) attr[3:0] = text_colour(n, SGR_FG_BASE, 1'b0);
         else if (in_span(n, SGR_FG_BRIGHT_BASE))
            attr[3:0] = text_colour(n, SGR_FG_BRIGHT_BASE, 1'b1);
         else if (in_span(n, SGR_BG_BASE)) attr[7:4] = text_colour(n, SGR_BG_BASE, 1'b0);
         else if (in_span(n, SGR_BG_BRIGHT_BASE))
            attr[7:4] = text_colour(n, SGR_BG_BRIGHT_BASE, 1'b1);
      endfunction

      function void final_byte(logic [7:0] c);
         logic [7:0] n;
         n = param;
         sequences_done++;
         case (c)
            CSI_CURSOR_UP: begin
               if (n > row) n = row;
               row = row - n;
            end
            CSI_CURSOR_DOWN:    row = row + n;
            CSI_CURSOR_FORWARD: col = col + n;
            CSI_CURSOR_BACK:    col = col - n;
            CSI_NEXT_LINE: begin
               col = '0;
               row = row + n;
            end
            CSI_PREV_LINE: begin
               col = '0;
               row = row - n;
            end
            CSI_COLUMN_ABS: col = n;
            CSI_POSITION, CSI_POSITION_ALT: if (two_params) begin
               col = first_param;
               row = n;
            end
            CSI_SGR: graphic_rendition(n);
            default: ;
         endcase
         mode = MODE_IDLE;
      endfunction

      function void note_byte(logic [7:0] c);
         result_type r;
         r = '0;
         bytes_noted++;
         case (mode)
            MODE_ESC: if (c == CHAR_LBRACKET) begin
               mode        = MODE_CSI;
               param       = '0;
               first_param = '0;
               two_params  = 1'b0;
            end else begin
               mode = MODE_IDLE;
               plain_byte(c, r);
            end
            MODE_CSI: if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
               param = param * 8'd10 + (c - CHAR_ZERO);
            end else if (c == CHAR_SEMICOLON) begin
               first_param = param;
               param       = '0;
               two_params  = 1'b1;
            end else begin
               final_byte(c);
            end
            default: begin
               mode = MODE_IDLE;
               plain_byte(c, r);
            end
         endcase
         r.cursor_position = 16'(cursor_index());
         expected_q.push_back(r);
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (expected_q.size() == 0) begin
            $error("result word with nothing expected, cursor_position %0h",
                   got.cursor_position);
            mismatches++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("cell_write", want.cell_write, got.cell_write);
         compare_field("cell_address", want.cell_address, got.cell_address);
         compare_field("cell_value", want.cell_value, got.cell_value);
         compare_field("cursor_position", want.cursor_position, got.cursor_position);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic        clock;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic [7:0]  req_input_byte   = '0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic        rsp_cell_write;
   logic [10:0] rsp_cell_address;
   logic [15:0] rsp_cell_value;
   logic [15:0] rsp_cursor_position;
   logic        csr_write_enable = 1'b0;
   logic        csr_index        = CSR_UNDERLINE_ENABLE;
   logic        csr_write_data   = 1'b0;

   cell_scoreboard board;

   // Idling percentages for the current phase, plus stretches with no idling
   int req_idle_pct    = 0;
   int rsp_idle_pct    = 0;
   int req_calm_left   = 0;
   int rsp_calm_left   = 0;
   int phase_bytes     = 0;
   int quiet_cycles    = 0;

   text_terminal_ansi_writer_core u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_input_byte      (req_input_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_cell_write      (rsp_cell_write),
      .rsp_cell_address    (rsp_cell_address),
      .rsp_cell_value      (rsp_cell_value),
      .rsp_cursor_position (rsp_cursor_position),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Sample both channels at the edge: what is seen here is what the block saw
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.note_byte(req_input_byte);
         if (rsp_valid && !rsp_stall)
            board.check_result({rsp_cell_write, rsp_cell_address, rsp_cell_value,
                                rsp_cursor_position});
      end
   end

   // Receiver back-pressure; drop it entirely for a random stretch now and then
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall     <= 1'b0;
         rsp_calm_left <= 0;
      end else if (rsp_calm_left > 0) begin
         rsp_stall     <= 1'b0;
         rsp_calm_left <= rsp_calm_left - 1;
      end else if ($urandom_range(0, 31) == 0) begin
         rsp_stall     <= 1'b0;
         rsp_calm_left <= $urandom_range(8, 30);
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
      end
   end

   // Abort when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // Offer one word, idling first at the phase's rate, and hold it until taken
   task automatic send_byte(input logic [7:0] b);
      forever begin
         if (req_calm_left > 0) begin
            req_calm_left--;
            break;
         end
         if ($urandom_range(0, 31) == 0) begin
            req_calm_left = $urandom_range(8, 30);
            break;
         end
         if ($urandom_range(0, 99) >= req_idle_pct) break;
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_input_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      phase_bytes++;
   endtask

   task automatic send_number(input int unsigned n);
      int unsigned digits[$];
      do begin
         digits.push_front(n % 10);
         n = n / 10;
      end while (n != 0);
      foreach (digits[i]) send_byte(CHAR_ZERO + 8'(digits[i]));
   endtask

   // ESC [ with parameters shaped to suit the final byte
   task automatic send_control_sequence(input logic [7:0] final_code);
      int unsigned n;
      send_byte(CHAR_ESC);
      send_byte(CHAR_LBRACKET);
      if (final_code == CSI_POSITION || final_code == CSI_POSITION_ALT) begin
         // column first; leave it out now and then so the command is ignored
         if ($urandom_range(0, 3) != 0) begin
            send_number(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                    : $urandom_range(0, COLUMNS - 1));
            send_byte(CHAR_SEMICOLON);
         end
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, ROWS - 1);
      end else if (final_code == CSI_SGR) begin
         case ($urandom_range(0, 9))
            0: n = SGR_RESET;
            1: n = SGR_BOLD;
            2: n = SGR_UNDERLINE;
            3: n = SGR_BLINK;
            4: n = SGR_REVERSE;
            5: n = SGR_NORMAL;
            6: n = SGR_FG_BASE + $urandom_range(0, 8);
            7: n = SGR_BG_BASE + $urandom_range(0, 8);
            8: n = ($urandom_range(0, 1) ? SGR_FG_BRIGHT_BASE : SGR_BG_BRIGHT_BASE)
                   + $urandom_range(0, 8);
            default: n = $urandom_range(0, 255);
         endcase
      end else begin
         // a stray first parameter must not disturb a single-parameter command
         if ($urandom_range(0, 7) == 0) begin
            send_number($urandom_range(0, 99));
            send_byte(CHAR_SEMICOLON);
         end
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
         // three digits past 255 wrap the accumulator
         if ($urandom_range(0, 15) == 0) n = $urandom_range(256, 999);
      end
      if ($urandom_range(0, 7) == 0) send_byte(CHAR_ZERO);
      // an empty parameter counts as zero
      if (n != 0 || $urandom_range(0, 1) == 0) send_number(n);
      send_byte(final_code);
   endtask

   // Lower valid, let every result arrive, then leave the block quiet a while
   task automatic settle_block();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [7:0] opening[$];
      logic [1:0] enable_plan[PHASES];

      board = new();
      // underline enable in bit 1, blink enable in bit 0; both extremes included
      enable_plan = '{2'b00, 2'b11, 2'b10, 2'b01, 2'b11, 2'b00};
      // Extremes of the byte, every plain control, escape then a plain byte,
      // a position command without its second parameter, a jump to the last
      // cell, a write past the screen end, a tab beyond the right edge and a
      // line feed on the last row
      opening = '{8'h41, 8'h00, 8'hFF, CHAR_BS, CHAR_TAB, CHAR_CR,
                  CHAR_ESC, 8'h78,
                  CHAR_ESC, CHAR_LBRACKET, CSI_POSITION,
                  CHAR_ESC, CHAR_LBRACKET, CHAR_ZERO + 8'd7, CHAR_ZERO + 8'd9,
                  CHAR_SEMICOLON, CHAR_ZERO + 8'd2, CHAR_ZERO + 8'd4, CSI_POSITION,
                  8'h5A, 8'h5A, CHAR_TAB, CHAR_LF};

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < PHASES; phase++) begin
         settle_block();

         // Write both enables while nothing is in flight
         csr_write_enable <= 1'b1;
         csr_index        <= CSR_UNDERLINE_ENABLE;
         csr_write_data   <= enable_plan[phase][1];
         @(posedge clock);
         csr_index        <= CSR_BLINK_ENABLE;
         csr_write_data   <= enable_plan[phase][0];
         @(posedge clock);
         csr_write_enable <= 1'b0;
         board.set_enables(enable_plan[phase][1], enable_plan[phase][0]);

         // Receiver idles more first, then the sender, then neither
         case (phase / 2)
            0: begin
               req_idle_pct = 26;
               rsp_idle_pct = 45;
            end
            1: begin
               req_idle_pct = 45;
               rsp_idle_pct = 26;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase

         if (phase == 0) foreach (opening[i]) send_byte(opening[i]);

         phase_bytes = 0;
         while (phase_bytes < ITEMS_PER_PHASE) begin
            int unsigned pick;
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
               // run of printable text
               repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(8'h20, 8'h7E)));
            end else if (pick < 45) begin
               case ($urandom_range(0, 3))
                  0: send_byte(CHAR_CR);
                  1: send_byte(CHAR_LF);
                  2: send_byte(CHAR_BS);
                  default: send_byte(CHAR_TAB);
               endcase
            end else if (pick < 55) begin
               // pull the cursor back somewhere on the screen
               send_control_sequence($urandom_range(0, 1) ? CSI_POSITION : CSI_POSITION_ALT);
            end else if (pick < 85) begin
               case ($urandom_range(0, 11))
                  0: send_control_sequence(CSI_CURSOR_UP);
                  1: send_control_sequence(CSI_CURSOR_DOWN);
                  2: send_control_sequence(CSI_CURSOR_FORWARD);
                  3: send_control_sequence(CSI_CURSOR_BACK);
                  4: send_control_sequence(CSI_NEXT_LINE);
                  5: send_control_sequence(CSI_PREV_LINE);
                  6: send_control_sequence(CSI_COLUMN_ABS);
                  7: send_control_sequence(CSI_POSITION);
                  8: send_control_sequence(CSI_POSITION_ALT);
                  11: send_control_sequence(8'($urandom_range(0, 255)));
                  default: send_control_sequence(CSI_SGR);
               endcase
            end else begin
               // noise and broken sequences
               case ($urandom_range(0, 3))
                  0: send_byte(8'($urandom_range(0, 255)));
                  1: begin
                     send_byte(CHAR_ESC);
                     send_byte(8'($urandom_range(0, 255)));
                  end
                  2: begin
                     send_byte(CHAR_ESC);
                     send_byte(CHAR_LBRACKET);
                     send_number($urandom_range(0, 99));
                     case ($urandom_range(0, 4))
                        0: send_byte(CHAR_ESC);
                        1: send_byte(8'h00);
                        2: send_byte(CSI_ERASE_DISPLAY);
                        3: send_byte(CSI_ERASE_LINE);
                        default: send_byte(8'($urandom_range(0, 255)));
                     endcase
                  end
                  default: send_byte(CHAR_ESC);
               endcase
            end
         end
      end

      settle_block();

      $display("covered %0d bytes over six phases of enables and idling, %0d escape sequences",
               board.bytes_noted, board.sequences_done);
      $display("%0d cells written, %0d writes dropped past the screen end",
               board.cells_written, board.cells_dropped);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/ttaw_pkg.sv
rtl/ttaw_sgr.sv
rtl/ttaw_engine.sv
rtl/text_terminal_ansi_writer_core.sv
sim/tb_text_terminal_ansi_writer_core.sv
